### rtl/roulette_wheel_selector_top_macros.svh
// Assertion macros shared by the checker of the roulette wheel selector.
// Each macro expects signals named clock and reset in the scope of its use.
`ifndef ROULETTE_WHEEL_SELECTOR_TOP_MACROS_SVH
`define ROULETTE_WHEEL_SELECTOR_TOP_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define RWS_ASSERT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define RWS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that is also checked around reset.
`define RWS_ASSERT_NEXT_RAW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/rws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Roulette wheel selector package
// Field widths, operation codes, defaults and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package rws_pkg;

   localparam int POP_MAX_DEF  = 64;
   localparam int FIT_BITS_DEF = 32;

   localparam int FUNC_W = 2;
   localparam int IDX_W  = 6;
   localparam int FIT_W  = 32;
   localparam int RND_W  = 16;
   localparam int POP_W  = 7;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [POP_W-1:0] POP_RESET = 7'd64;

   // Register index, taken from the word address of the configuration port.
   localparam logic [CSR_ADDR_W-3:0] REG_POP_SIZE = 1'b0;

   localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_SELECT = 2'd2;

   typedef struct packed {
      logic latch;       // take the input word
      logic res_init;    // preset the result of the word
      logic cnt_clear;   // restart the entry counter
      logic sweep_wr;    // write zero at the counter, advance it
      logic total_clear; // zero the running total
      logic ld_rd;       // read the entry a load replaces
      logic ld_wr;       // write the new entry, adjust the total
      logic mul;         // form the two partial products of the slice
      logic slice;       // sum the slice, restart the walk
      logic walk_issue;  // read the entry at the counter, advance it
      logic walk_acc;    // add the entry just read to the running sum
      logic hit_cap;     // the entry just read is the chosen one
      logic zero_rd;     // read entry zero
      logic zero_cap;    // entry zero is the chosen one
      logic out_load;    // move the result to the output register
   } cmd_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              in_range;   // load index below the size in use
      logic              more;       // walk counter below the size in use
      logic              hit;        // running sum passes the slice
      logic              sweep_last; // counter at the last table entry
   } sts_type;

endpackage

### rtl/rws_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Roulette wheel selector channels
// Valid/ready channels for the request word and the response word.
// ----------------------------------------------------------------------------
interface rws_req_if;
   logic                        valid;
   logic                        ready;
   logic [rws_pkg::FUNC_W-1:0]  func;
   logic [rws_pkg::IDX_W-1:0]   entry_index;
   logic [rws_pkg::FIT_W-1:0]   fitness_value;
   logic [rws_pkg::RND_W-1:0]   random_fraction;

   modport source (output valid, func, entry_index, fitness_value, random_fraction,
                   input ready);
   modport sink (input valid, func, entry_index, fitness_value, random_fraction,
                 output ready);
endinterface

interface rws_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [rws_pkg::IDX_W-1:0]   chosen_index;
   logic [rws_pkg::FIT_W-1:0]   chosen_fitness;
   logic                        status;

   modport source (output valid, chosen_index, chosen_fitness, status, input ready);
   modport sink (input valid, chosen_index, chosen_fitness, status, output ready);
endinterface

### rtl/rws_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rws_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/rws_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Roulette wheel selector configuration registers
// APB-style register port holding the population size.
// ----------------------------------------------------------------------------
module rws_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [rws_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [rws_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [rws_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready,
   output logic [rws_pkg::POP_W-1:0]      pop_size
);

   logic [rws_pkg::POP_W-1:0]        pop_size_ff;
   logic [rws_pkg::POP_W-1:0]        pop_size_in;
   logic [rws_pkg::CSR_ADDR_W-3:0]   reg_sel;
   logic                             wr_hit;

   assign reg_sel = paddr[rws_pkg::CSR_ADDR_W-1:2];
   assign wr_hit  = psel && penable && pwrite && (reg_sel == rws_pkg::REG_POP_SIZE);

   always_comb begin
      pop_size_in = pop_size_ff;
      if (wr_hit) begin
         pop_size_in = pwdata[rws_pkg::POP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pop_size_ff <= rws_pkg::POP_RESET;
      end else begin
         pop_size_ff <= pop_size_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (reg_sel == rws_pkg::REG_POP_SIZE) begin
         prdata = rws_pkg::CSR_DATA_W'(pop_size_ff);
      end
   end

   assign pready   = 1'b1;
   assign pop_size = pop_size_ff;

endmodule

### rtl/rws_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Roulette wheel selector controller
// Sequences clear sweeps, loads and the selection walk over the table.
// ----------------------------------------------------------------------------
module rws_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rws_pkg::cmd_type  cmd,
   input  rws_pkg::sts_type  sts
);

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_DISP,
      S_CLEAR,
      S_LDWR,
      S_MUL,
      S_SLICE,
      S_WALK,
      S_ZCAP,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      pend_ff, pend_in;     // a walk read is in flight
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      case (state_ff)
         S_INIT: begin
            cmd.sweep_wr = 1'b1;
            if (sts.sweep_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_DISP;
            end
         end
         S_DISP: begin
            cmd.res_init = 1'b1;
            case (sts.func)
               rws_pkg::FUNC_CLEAR: begin
                  cmd.cnt_clear = 1'b1;
                  state_in      = S_CLEAR;
               end
               rws_pkg::FUNC_LOAD: begin
                  if (sts.in_range) begin
                     cmd.ld_rd = 1'b1;
                     state_in  = S_LDWR;
                  end else begin
                     state_in  = S_DONE;
                  end
               end
               rws_pkg::FUNC_SELECT: begin
                  state_in = S_MUL;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_CLEAR: begin
            cmd.sweep_wr = 1'b1;
            if (sts.sweep_last) begin
               cmd.total_clear = 1'b1;
               state_in        = S_DONE;
            end
         end
         S_LDWR: begin
            cmd.ld_wr = 1'b1;
            state_in  = S_DONE;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_SLICE;
         end
         S_SLICE: begin
            cmd.slice = 1'b1;
            pend_in   = 1'b0;
            state_in  = S_WALK;
         end
         S_WALK: begin
            if (pend_ff && sts.hit) begin
               cmd.hit_cap = 1'b1;
               pend_in     = 1'b0;
               state_in    = S_DONE;
            end else begin
               cmd.walk_acc = pend_ff;
               if (sts.more) begin
                  cmd.walk_issue = 1'b1;
                  pend_in        = 1'b1;
               end else if (pend_ff) begin
                  pend_in = 1'b0;
               end else begin
                  cmd.zero_rd = 1'b1;
                  state_in    = S_ZCAP;
               end
            end
         end
         S_ZCAP: begin
            cmd.zero_cap = 1'b1;
            state_in     = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

### rtl/rws_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Roulette wheel selector datapath
// Fitness table, running total, slice multiplier and the selection walk.
// ----------------------------------------------------------------------------
module rws_dpath #(
   parameter int POP_MAX  = rws_pkg::POP_MAX_DEF,
   parameter int FIT_BITS = rws_pkg::FIT_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  rws_pkg::cmd_type            cmd,
   output rws_pkg::sts_type            sts,
   input  logic [rws_pkg::FUNC_W-1:0]  req_func,
   input  logic [rws_pkg::IDX_W-1:0]   req_entry_index,
   input  logic [rws_pkg::FIT_W-1:0]   req_fitness_value,
   input  logic [rws_pkg::RND_W-1:0]   req_random_fraction,
   input  logic [rws_pkg::POP_W-1:0]   pop_size,
   output logic [rws_pkg::IDX_W-1:0]   rsp_chosen_index,
   output logic [rws_pkg::FIT_W-1:0]   rsp_chosen_fitness,
   output logic                        rsp_status
);

   localparam int ADDR_W = $clog2(POP_MAX);
   localparam int CNT_W  = ADDR_W + 1;
   localparam int N_W    = (CNT_W > rws_pkg::POP_W) ? CNT_W : rws_pkg::POP_W;
   localparam int TOT_W  = FIT_BITS + ADDR_W;
   localparam int EXT_W  = (TOT_W > rws_pkg::RND_W) ? TOT_W : rws_pkg::RND_W + 1;
   localparam int LO_W   = 2 * rws_pkg::RND_W;

   // Item registers.
   logic [rws_pkg::FUNC_W-1:0] func_ff, func_in;
   logic [rws_pkg::IDX_W-1:0]  idx_ff, idx_in;
   logic [FIT_BITS-1:0]        fit_ff, fit_in;
   logic [rws_pkg::RND_W-1:0]  rnd_ff, rnd_in;

   // Working state.
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [ADDR_W-1:0] chk_ff, chk_in;
   logic [TOT_W-1:0]  total_ff, total_in;
   logic [TOT_W-1:0]  slice_ff, slice_in;
   logic [TOT_W-1:0]  run_ff, run_in;
   logic [EXT_W-1:0]  hi_ff, hi_in;
   logic [LO_W-1:0]   lo_ff, lo_in;

   // Result and output registers.
   logic [ADDR_W-1:0]         chosen_ff, chosen_in;
   logic [FIT_BITS-1:0]       cfit_ff, cfit_in;
   logic                      stat_ff, stat_in;
   logic [rws_pkg::IDX_W-1:0] out_idx_ff, out_idx_in;
   logic [rws_pkg::FIT_W-1:0] out_fit_ff, out_fit_in;
   logic                      out_stat_ff, out_stat_in;

   // Table port signals.
   logic                ram_we;
   logic [ADDR_W-1:0]   ram_waddr;
   logic [FIT_BITS-1:0] ram_wdata;
   logic                ram_re;
   logic [ADDR_W-1:0]   ram_raddr;
   logic [FIT_BITS-1:0] ram_rdata;

   logic [N_W-1:0]    size_ext;
   logic [N_W-1:0]    n_use;
   logic [ADDR_W-1:0] idx_addr;
   logic [EXT_W-1:0]  tot_ext;
   logic [TOT_W-1:0]  run_sum;
   logic              in_range;

   assign size_ext = N_W'(pop_size);
   assign n_use    = (size_ext < N_W'(POP_MAX)) ? size_ext : N_W'(POP_MAX);
   assign in_range = N_W'(idx_ff) < n_use;
   assign idx_addr = ADDR_W'(idx_ff);
   assign tot_ext  = EXT_W'(total_ff);
   assign run_sum  = run_ff + TOT_W'(ram_rdata);

   assign sts.func       = func_ff;
   assign sts.in_range   = in_range;
   assign sts.more       = N_W'(cnt_ff) < n_use;
   assign sts.hit        = run_sum > slice_ff;
   assign sts.sweep_last = cnt_ff == CNT_W'(POP_MAX - 1);

   // Table ports.
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = cnt_ff[ADDR_W-1:0];
      ram_wdata = '0;
      if (cmd.sweep_wr) begin
         ram_we = 1'b1;
      end else if (cmd.ld_wr) begin
         ram_we    = 1'b1;
         ram_waddr = idx_addr;
         ram_wdata = fit_ff;
      end
   end

   always_comb begin
      ram_re    = cmd.ld_rd || cmd.walk_issue || cmd.zero_rd;
      ram_raddr = '0;
      if (cmd.ld_rd) begin
         ram_raddr = idx_addr;
      end else if (cmd.walk_issue) begin
         ram_raddr = cnt_ff[ADDR_W-1:0];
      end
   end

   rws_ram #(
      .WIDTH (FIT_BITS),
      .DEPTH (POP_MAX)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Next values.
   always_comb begin
      func_in     = func_ff;
      idx_in      = idx_ff;
      fit_in      = fit_ff;
      rnd_in      = rnd_ff;
      cnt_in      = cnt_ff;
      chk_in      = chk_ff;
      total_in    = total_ff;
      slice_in    = slice_ff;
      run_in      = run_ff;
      hi_in       = hi_ff;
      lo_in       = lo_ff;
      chosen_in   = chosen_ff;
      cfit_in     = cfit_ff;
      stat_in     = stat_ff;
      out_idx_in  = out_idx_ff;
      out_fit_in  = out_fit_ff;
      out_stat_in = out_stat_ff;

      if (cmd.latch) begin
         func_in = req_func;
         idx_in  = req_entry_index;
         fit_in  = FIT_BITS'(req_fitness_value);
         rnd_in  = req_random_fraction;
      end
      if (cmd.res_init) begin
         chosen_in = '0;
         cfit_in   = '0;
         stat_in   = (func_ff == rws_pkg::FUNC_LOAD) && !in_range;
      end
      if (cmd.cnt_clear) begin
         cnt_in = '0;
      end
      if (cmd.sweep_wr) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end
      if (cmd.total_clear) begin
         total_in = '0;
      end
      if (cmd.ld_wr) begin
         total_in = total_ff - TOT_W'(ram_rdata) + TOT_W'(fit_ff);
      end
      if (cmd.mul) begin
         // Slice is (total * r) >> 16, split at bit 16 of the total.
         hi_in = EXT_W'(tot_ext[EXT_W-1:rws_pkg::RND_W]) * EXT_W'(rnd_ff);
         lo_in = LO_W'(tot_ext[rws_pkg::RND_W-1:0]) * LO_W'(rnd_ff);
      end
      if (cmd.slice) begin
         slice_in = TOT_W'(hi_ff + EXT_W'(lo_ff[LO_W-1:rws_pkg::RND_W]));
         run_in   = '0;
         cnt_in   = '0;
      end
      if (cmd.walk_acc) begin
         run_in = run_sum;
      end
      if (cmd.walk_issue) begin
         chk_in = cnt_ff[ADDR_W-1:0];
         cnt_in = cnt_ff + CNT_W'(1);
      end
      if (cmd.hit_cap) begin
         chosen_in = chk_ff;
         cfit_in   = ram_rdata;
      end
      if (cmd.zero_cap) begin
         chosen_in = '0;
         cfit_in   = ram_rdata;
      end
      if (cmd.out_load) begin
         out_idx_in  = rws_pkg::IDX_W'(chosen_ff);
         out_fit_in  = rws_pkg::FIT_W'(cfit_ff);
         out_stat_in = stat_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         total_ff <= '0;
      end else begin
         cnt_ff   <= cnt_in;
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      idx_ff      <= idx_in;
      fit_ff      <= fit_in;
      rnd_ff      <= rnd_in;
      chk_ff      <= chk_in;
      slice_ff    <= slice_in;
      run_ff      <= run_in;
      hi_ff       <= hi_in;
      lo_ff       <= lo_in;
      chosen_ff   <= chosen_in;
      cfit_ff     <= cfit_in;
      stat_ff     <= stat_in;
      out_idx_ff  <= out_idx_in;
      out_fit_ff  <= out_fit_in;
      out_stat_ff <= out_stat_in;
   end

   assign rsp_chosen_index   = out_idx_ff;
   assign rsp_chosen_fitness = out_fit_ff;
   assign rsp_status         = out_stat_ff;

endmodule

### rtl/roulette_wheel_selector_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Roulette wheel selector
// Fitness proportionate selection over a table of Q16.16 member fitness
// values with clear, load and select operations.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Contents
//  req_ch    in         valid/ready          func, entry_index, fitness_value,
//                                            random_fraction
//  rsp_ch    out        valid/ready          chosen_index, chosen_fitness, status
//  csr_*     in/out     APB setup + access   pop_size at byte address 0
//
//  A load reads the entry it replaces, then writes the new entry and adjusts
//  the total; a rejected load goes straight to its result, and a clear sweeps
//  the table to zero, then zeros the total. A select forms the slice in a
//  multiply step and a sum step; the table has one read port and the walk
//  reads one entry per cycle. After reset the table is swept to zero, with
//  req_ch not ready. The next word is taken while a finished result still
//  waits in the output register; a stalled rsp_ch holds only the word being
//  completed.
// ----------------------------------------------------------------------------
module roulette_wheel_selector_top #(
   parameter int POP_MAX  = rws_pkg::POP_MAX_DEF,
   parameter int FIT_BITS = rws_pkg::FIT_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   rws_req_if.sink                        req_ch,
   rws_rsp_if.source                      rsp_ch,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [rws_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [rws_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [rws_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);

   rws_pkg::cmd_type           cmd;
   rws_pkg::sts_type           sts;
   logic [rws_pkg::POP_W-1:0]  pop_size;

   // Population size register, written by the user only while idle; unchecked.
   rws_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (csr_psel),
      .penable  (csr_penable),
      .pwrite   (csr_pwrite),
      .paddr    (csr_paddr),
      .pwdata   (csr_pwdata),
      .prdata   (csr_prdata),
      .pready   (csr_pready),
      .pop_size (pop_size)
   );

   // The controller owns the handshakes and steps the datapath one command
   // set per cycle.
   rws_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // The datapath holds the table, the total, the slice and the output word.
   rws_dpath #(
      .POP_MAX  (POP_MAX),
      .FIT_BITS (FIT_BITS)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_func            (req_ch.func),
      .req_entry_index     (req_ch.entry_index),
      .req_fitness_value   (req_ch.fitness_value),
      .req_random_fraction (req_ch.random_fraction),
      .pop_size            (pop_size),
      .rsp_chosen_index    (rsp_ch.chosen_index),
      .rsp_chosen_fitness  (rsp_ch.chosen_fitness),
      .rsp_status          (rsp_ch.status)
   );

endmodule

### rtl/rws_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Roulette wheel selector checker
// Port-level checks on word ordering and result contents.
// ----------------------------------------------------------------------------
`include "roulette_wheel_selector_top_macros.svh"

module rws_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [rws_pkg::IDX_W-1:0]  rsp_chosen_index,
   input logic [rws_pkg::FIT_W-1:0]  rsp_chosen_fitness,
   input logic                       rsp_status
);

   // Words accepted whose result has not yet been delivered.
   logic [1:0] pend_ff, pend_in;
   logic       in_acc;
   logic       out_acc;

   assign in_acc  = req_valid && req_ready;
   assign out_acc = rsp_valid && rsp_ready;

   always_comb begin
      pend_in = pend_ff + 2'(in_acc) - 2'(out_acc);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 2'd0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   `RWS_ASSERT_NEXT_RAW(a_reset_empty, reset, !rsp_valid, "response valid after reset")
   `RWS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_chosen_index) && $stable(rsp_chosen_fitness) && $stable(rsp_status), "stalled response changed")
   `RWS_ASSERT(a_rsp_has_word, rsp_valid, pend_ff != 2'd0, "response without an accepted word")
   `RWS_ASSERT(a_pend_bound, 1'b1, pend_ff != 2'd3, "more than two words in flight")
   `RWS_ASSERT(a_flag_zero, rsp_valid && rsp_status, rsp_chosen_index == '0 && rsp_chosen_fitness == '0, "flagged load with nonzero result")

endmodule

bind roulette_wheel_selector_top rws_checker u_rws_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_ch.valid),
   .req_ready          (req_ch.ready),
   .rsp_valid          (rsp_ch.valid),
   .rsp_ready          (rsp_ch.ready),
   .rsp_chosen_index   (rsp_ch.chosen_index),
   .rsp_chosen_fitness (rsp_ch.chosen_fitness),
   .rsp_status         (rsp_ch.status)
);

### bench/roulette_wheel_selector_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Roulette wheel selector testbench
// Drives clear, load and select words through the request channel and checks
// each response word against a predictor of the fitness table, its running
// total and the pop_size register, under random idling on both channels.
// ----------------------------------------------------------------------------
module roulette_wheel_selector_top_tb;

   // The fourth function code does nothing but must still answer with a zero word.
   localparam logic [rws_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam logic [rws_pkg::CSR_ADDR_W-1:0] POP_SIZE_ADDR = {rws_pkg::REG_POP_SIZE, 2'b00};
   localparam int CYCLE_LIMIT = 1000000;
   // A clear sweeps POP_MAX entries and a select walks up to POP_MAX entries,
   // so a little more than that covers any word still in flight.
   localparam int DRAIN_CYCLES = rws_pkg::POP_MAX_DEF + 16;
   localparam int PRINT_CAP = 40;

   typedef struct packed {
      bit [rws_pkg::FUNC_W-1:0] func;
      bit [rws_pkg::IDX_W-1:0]  idx;
      bit [rws_pkg::FIT_W-1:0]  fit;
      bit [rws_pkg::RND_W-1:0]  rnd;
   } wheel_word_type;

   typedef struct packed {
      bit [rws_pkg::IDX_W-1:0] idx;
      bit [rws_pkg::FIT_W-1:0] fit;
      bit                      status;
   } choice_type;

   logic clock = 1'b0;
   logic reset;

   logic                           csr_psel;
   logic                           csr_penable;
   logic                           csr_pwrite;
   logic [rws_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [rws_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [rws_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   rws_req_if req_ch ();
   rws_rsp_if rsp_ch ();

   roulette_wheel_selector_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Shadow copy of the block's state, updated as each request word is taken.
   bit [rws_pkg::FIT_W-1:0] fit_tab [rws_pkg::POP_MAX_DEF];
   bit [37:0]               total_fit;
   bit [rws_pkg::POP_W-1:0] pop_cfg;

   // Response words the block still owes, oldest first.
   choice_type choices_due [$];

   int  errors;
   int  cycles;
   int  words_sent;
   int  selects_sent;
   int  rejected_loads;
   int  sizes_tried;
   bit  gaps_on;
   int  stall_left = 0;

   // The clock is high for the first half of each 10 ns period.
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words still due", cycles,
                  choices_due.size());
         $display("simulation failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input bit [63:0] got,
                                  input bit [63:0] want);
      errors++;
      if (errors <= PRINT_CAP)
         $display("%0t mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what,
                  got, want);
   endtask

   // Applies one request word to the shadow state and returns the response
   // word the block must give for it.
   function automatic choice_type spin_wheel(input wheel_word_type w);
      choice_type c;
      int         n;
      bit [63:0]  slice_v;
      bit [63:0]  run;
      bit         hit;
      c = '0;
      n = (pop_cfg < rws_pkg::POP_MAX_DEF) ? pop_cfg : rws_pkg::POP_MAX_DEF;
      case (w.func)
         rws_pkg::FUNC_CLEAR: begin
            foreach (fit_tab[i]) fit_tab[i] = '0;
            total_fit = '0;
         end
         rws_pkg::FUNC_LOAD: begin
            if (w.idx < n) begin
               total_fit = total_fit - fit_tab[w.idx] + w.fit;
               fit_tab[w.idx] = w.fit;
            end else begin
               c.status = 1'b1;
            end
         end
         rws_pkg::FUNC_SELECT: begin
            // The slice is floor(fraction * total / 2^16); 38 bits at most.
            slice_v = (64'(total_fit) * 64'(w.rnd)) >> 16;
            run = '0;
            hit = 1'b0;
            for (int i = 0; i < n && !hit; i++) begin
               run += fit_tab[i];
               if (run > slice_v) begin
                  hit = 1'b1;
                  c.idx = rws_pkg::IDX_W'(i);
               end
            end
            // Without a hit the choice falls back to entry zero.
            c.fit = fit_tab[c.idx];
         end
         default: begin
         end
      endcase
      return c;
   endfunction

   // Response checker: every accepted response word is matched against the
   // oldest word still due.
   always @(posedge clock) begin
      choice_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (choices_due.size() == 0) begin
            report_mismatch("unexpected response word", 64'({rsp_ch.chosen_index,
                            rsp_ch.chosen_fitness, rsp_ch.status}), '0);
         end else begin
            want = choices_due.pop_front();
            if (rsp_ch.chosen_index !== want.idx)
               report_mismatch("chosen_index", 64'(rsp_ch.chosen_index), 64'(want.idx));
            if (rsp_ch.chosen_fitness !== want.fit)
               report_mismatch("chosen_fitness", 64'(rsp_ch.chosen_fitness),
                               64'(want.fit));
            if (rsp_ch.status !== want.status)
               report_mismatch("status", 64'(rsp_ch.status), 64'(want.status));
         end
      end
   end

   // The response side stalls in random bursts while gaps are on.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_ch.ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(0, 16);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // Sends one request word, with a random gap before it while gaps are on.
   // The word is folded into the shadow state at the edge that takes it.
   task automatic send_word(input logic [rws_pkg::FUNC_W-1:0] func,
                            input logic [rws_pkg::IDX_W-1:0] idx,
                            input logic [rws_pkg::FIT_W-1:0] fit,
                            input logic [rws_pkg::RND_W-1:0] rnd);
      wheel_word_type w;
      choice_type     c;
      w = '{func: func, idx: idx, fit: fit, rnd: rnd};
      @(negedge clock);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_ch.valid = 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_ch.valid           = 1'b1;
      req_ch.func            = w.func;
      req_ch.entry_index     = w.idx;
      req_ch.fitness_value   = w.fit;
      req_ch.random_fraction = w.rnd;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      c = spin_wheel(w);
      choices_due = {choices_due, c};
      words_sent++;
      if (w.func == rws_pkg::FUNC_SELECT) selects_sent++;
      if (c.status) rejected_loads++;
   endtask

   // One APB transfer: a setup phase, then an access phase that completes at
   // the rising edge where pready is high.
   task automatic csr_access(input bit wr, input logic [rws_pkg::CSR_DATA_W-1:0] wdata,
                             output logic [rws_pkg::CSR_DATA_W-1:0] rdata);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = wr;
      csr_paddr   = POP_SIZE_ADDR;
      csr_pwdata  = wdata;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      if (wr) pop_cfg = wdata[rws_pkg::POP_W-1:0];
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   task automatic check_pop_size(input logic [rws_pkg::POP_W-1:0] want);
      logic [rws_pkg::CSR_DATA_W-1:0] rdata;
      csr_access(1'b0, '0, rdata);
      if (rdata !== rws_pkg::CSR_DATA_W'(want))
         report_mismatch("pop_size readback", 64'(rdata), 64'(want));
   endtask

   // The register is only written with the request channel quiet and every
   // response word delivered.
   task automatic write_pop_size(input logic [rws_pkg::POP_W-1:0] value);
      logic [rws_pkg::CSR_DATA_W-1:0] rdata;
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (choices_due.size() != 0) @(negedge clock);
      csr_access(1'b1, rws_pkg::CSR_DATA_W'(value), rdata);
      sizes_tried++;
      check_pop_size(value);
   endtask

   function automatic logic [rws_pkg::FIT_W-1:0] pick_fitness(input int mode);
      case (mode)
         0:       return '0;
         1:       return '1;
         2:       return $urandom_range(1, 65535);
         3:       return $urandom;
         default: return $urandom >> $urandom_range(0, 31);
      endcase
   endfunction

   function automatic logic [rws_pkg::RND_W-1:0] pick_fraction();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return rws_pkg::RND_W'($urandom);
      endcase
   endfunction

   function automatic logic [rws_pkg::FUNC_W-1:0] any_func();
      return rws_pkg::FUNC_W'($urandom);
   endfunction

   function automatic logic [rws_pkg::IDX_W-1:0] any_idx();
      return rws_pkg::IDX_W'($urandom);
   endfunction

   function automatic logic [rws_pkg::RND_W-1:0] any_rnd();
      return rws_pkg::RND_W'($urandom);
   endfunction

   // Right after reset: the register reads its reset value, an empty table
   // selects entry zero, and the unused code answers with zeros.
   task automatic test_reset_state();
      check_pop_size(rws_pkg::POP_RESET);
      send_word(rws_pkg::FUNC_SELECT, 6'd21, 32'hdead_beef, 16'h1234);
      send_word(FUNC_UNUSED, 6'd63, '1, '1);
   endtask

   // Extreme fitness values at both ends of the table, extreme fractions,
   // replacing an entry, and a select on a cleared table.
   task automatic test_table_extremes();
      send_word(rws_pkg::FUNC_CLEAR, '1, '1, '1);
      send_word(rws_pkg::FUNC_LOAD, 6'd0, '1, '1);
      send_word(rws_pkg::FUNC_LOAD, 6'd63, '1, '0);
      send_word(rws_pkg::FUNC_LOAD, 6'd5, 32'd1, 16'h5555);
      send_word(rws_pkg::FUNC_SELECT, 6'd63, '0, '0);
      send_word(rws_pkg::FUNC_SELECT, 6'd0, '1, '1);
      send_word(rws_pkg::FUNC_SELECT, 6'd42, 32'h1234_5678, 16'h8000);
      send_word(rws_pkg::FUNC_LOAD, 6'd63, '0, '1);
      send_word(rws_pkg::FUNC_SELECT, '0, '0, '1);
      send_word(rws_pkg::FUNC_CLEAR, '0, '0, '0);
      send_word(rws_pkg::FUNC_SELECT, 6'd7, 32'h0000_ffff, '1);
   endtask

   // Loads beyond the size in use, a size of zero, a size above POP_MAX and a
   // shrunk size that leaves entries outside the walk but inside the total.
   task automatic test_size_extremes();
      write_pop_size(7'd16);
      send_word(rws_pkg::FUNC_LOAD, 6'd16, 32'h0003_0000, '0);
      send_word(rws_pkg::FUNC_LOAD, 6'd63, 32'h0003_0000, '0);
      send_word(rws_pkg::FUNC_LOAD, 6'd0, 32'h0123_4567, '0);
      send_word(rws_pkg::FUNC_LOAD, 6'd15, 32'h0001_8000, '0);
      send_word(rws_pkg::FUNC_SELECT, '0, '0, '1);
      write_pop_size(7'd0);
      send_word(rws_pkg::FUNC_LOAD, 6'd0, '1, '0);
      send_word(rws_pkg::FUNC_SELECT, '0, '0, '1);
      write_pop_size(7'd127);
      send_word(rws_pkg::FUNC_LOAD, 6'd63, 32'h8000_0000, '0);
      send_word(rws_pkg::FUNC_SELECT, '0, '0, 16'hc000);
      write_pop_size(7'd1);
      send_word(rws_pkg::FUNC_SELECT, '0, '0, '1);
   endtask

   // Phases at several sizes. Most traffic is a well formed sequence of loads
   // followed by selects; the rest is whole-table fills, loads at random
   // indexes, clears, lone selects and the unused code. The last phase runs
   // without any idling.
   task automatic test_random_phases();
      logic [rws_pkg::POP_W-1:0] sizes [10];
      int quota;
      int eff;
      int kind;
      int mode;
      sizes = '{7'd64, 7'd127, 7'd1, 7'd40, 7'd0, 7'd2, 7'd64, 7'd17, 7'd100, 7'd64};
      sizes[7] = rws_pkg::POP_W'($urandom_range(3, 63));
      sizes[8] = rws_pkg::POP_W'($urandom_range(65, 126));
      for (int p = 0; p < 10; p++) begin
         gaps_on = (p != 9);
         write_pop_size(sizes[p]);
         eff = (pop_cfg < rws_pkg::POP_MAX_DEF) ? pop_cfg : rws_pkg::POP_MAX_DEF;
         quota = words_sent + 130;
         while (words_sent < quota) begin
            if (p != 9) gaps_on = ($urandom_range(0, 4) != 0);
            kind = $urandom_range(0, 15);
            if (kind < 9) begin
               if (kind < 3) send_word(rws_pkg::FUNC_CLEAR, any_idx(), $urandom, any_rnd());
               repeat ($urandom_range(1, 8)) begin
                  send_word(rws_pkg::FUNC_LOAD,
                            (eff > 0) ? rws_pkg::IDX_W'($urandom_range(0, eff - 1))
                                      : any_idx(),
                            pick_fitness($urandom_range(0, 4)), any_rnd());
               end
               repeat ($urandom_range(1, 6))
                  send_word(rws_pkg::FUNC_SELECT, any_idx(), $urandom, pick_fraction());
            end else if (kind < 11) begin
               mode = $urandom_range(0, 4);
               for (int i = 0; i < eff; i++)
                  send_word(rws_pkg::FUNC_LOAD, rws_pkg::IDX_W'(i), pick_fitness(mode),
                            any_rnd());
               repeat ($urandom_range(2, 6))
                  send_word(rws_pkg::FUNC_SELECT, any_idx(), $urandom, pick_fraction());
            end else if (kind == 11) begin
               send_word(rws_pkg::FUNC_LOAD, any_idx(), $urandom, any_rnd());
            end else if (kind == 12) begin
               send_word(FUNC_UNUSED, any_idx(), $urandom, any_rnd());
            end else if (kind == 13) begin
               send_word(rws_pkg::FUNC_CLEAR, any_idx(), $urandom, any_rnd());
            end else begin
               send_word(rws_pkg::FUNC_SELECT, any_idx(), $urandom, pick_fraction());
            end
         end
      end
   endtask

   initial begin
      reset                  = 1'b1;
      req_ch.valid           = 1'b0;
      req_ch.func            = rws_pkg::FUNC_CLEAR;
      req_ch.entry_index     = '0;
      req_ch.fitness_value   = '0;
      req_ch.random_fraction = '0;
      csr_psel               = 1'b0;
      csr_penable            = 1'b0;
      csr_pwrite             = 1'b0;
      csr_paddr              = '0;
      csr_pwdata             = '0;
      gaps_on                = 1'b1;
      foreach (fit_tab[i]) fit_tab[i] = '0;
      total_fit = '0;
      pop_cfg   = rws_pkg::POP_RESET;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // The block sweeps its table after reset; the first word simply waits
      // for req_ch to become ready.
      test_reset_state();
      test_table_extremes();
      test_size_extremes();
      test_random_phases();

      @(negedge clock);
      req_ch.valid = 1'b0;
      while (choices_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d request words (%0d selects, %0d rejected loads) in %0d cycles",
               words_sent, selects_sent, rejected_loads, cycles);
      $display("pop_size written %0d times, including 0, 1, 64 and 127", sizes_tried);
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("%0d mismatches", errors);
         $display("simulation failed");
      end
      $finish;
   end

endmodule

### roulette_wheel_selector_top.f
+incdir+rtl
rtl/rws_pkg.sv
rtl/rws_if.sv
rtl/rws_ram.sv
rtl/rws_csr.sv
rtl/rws_ctrl.sv
rtl/rws_dpath.sv
rtl/roulette_wheel_selector_top.sv
rtl/rws_checker.sv
bench/roulette_wheel_selector_top_tb.sv
